// ===== rtl/akf_pkg.sv =====
// Shared types, widths and arithmetic helpers for the angle/bias Kalman filter.
// Used by akf_mul, akf_div and angle_kalman_filter_core; depends on nothing.
package akf_pkg;

    localparam int AXES_DEF = 2;

    localparam int NOISE_W = 29;
    localparam int IDX_W   = 2;

    // serial multiplier operand and product widths
    localparam int MW = 36;
    localparam int PW = 2 * MW;
    // serial divider dividend and divisor widths
    localparam int DNW = 60;
    localparam int DDW = 32;

    localparam logic [IDX_W-1:0] REG_ANGLE_NOISE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_BIAS_NOISE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_MEASURE_NOISE = 2'd2;

    localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST   = 29'd268435;
    localparam logic [NOISE_W-1:0] BIAS_NOISE_RST    = 29'd805306;
    localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 29'd8053064;

    typedef struct packed {
        logic              axis;
        logic signed [31:0] measured_angle;
        logic signed [31:0] measured_rate;
        logic [23:0]       time_step;
    } t_in;

    typedef struct packed {
        logic              axis_out;
        logic signed [31:0] filtered_angle;
        logic signed [31:0] bias_estimate;
        logic              saturated;
    } t_out;

    function automatic logic signed [PW-1:0] ext32(input logic signed [31:0] v);
        return {{(PW-32){v[31]}}, v};
    endfunction

    function automatic logic signed [PW-1:0] ext34(input logic signed [33:0] v);
        return {{(PW-34){v[33]}}, v};
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                                 input int s);
        logic signed [PW-1:0] one;
        one = 1;
        return (v + (one <<< (s - 1))) >>> s;
    endfunction

    // {clip flag, value}
    function automatic logic [32:0] sat32(input logic signed [PW-1:0] v);
        logic [32:0] r;
        if ((&v[PW-1:31]) || !(|v[PW-1:31])) begin
            r = {1'b0, v[31:0]};
        end else if (v[PW-1]) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        return r;
    endfunction

    // {clip flag, gain} from quotient magnitude and sign
    function automatic logic [32:0] sat_gain(input logic [DNW-1:0] q, input logic neg);
        logic [31:0] m;
        logic        f;
        if (|q[DNW-1:31]) begin
            m = 32'h7FFF_FFFF;
            f = 1'b1;
        end else begin
            m = q[31:0];
            f = 1'b0;
        end
        return {f, (neg ? -m : m)};
    endfunction

endpackage

// ===== rtl/akf_mul.sv =====
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on akf_pkg for operand and product widths.
module akf_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [akf_pkg::MW-1:0] i_a,
    input  logic signed [akf_pkg::MW-1:0] i_b,
    output logic                          o_done,
    output logic signed [akf_pkg::PW-1:0] o_p
);
    localparam int MW = akf_pkg::MW;
    localparam int CW = $clog2(MW);

    logic            r_busy, r_fin, r_done, r_neg;
    logic [CW-1:0]   r_cnt;
    logic [MW-1:0]   r_ma;
    logic [2*MW-1:0] r_acc;
    logic signed [akf_pkg::PW-1:0] r_p;
    logic [MW-1:0]   w_abs_a, w_abs_b;
    logic [MW:0]     w_hi;

    assign w_abs_a = i_a[MW-1] ? MW'(-i_a) : MW'(i_a);
    assign w_abs_b = i_b[MW-1] ? MW'(-i_b) : MW'(i_b);
    assign w_hi    = {1'b0, r_acc[2*MW-1:MW]} + (r_acc[0] ? {1'b0, r_ma} : {(MW+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ma   <= w_abs_a;
                r_acc  <= {{MW{1'b0}}, w_abs_b};
                r_neg  <= i_a[MW-1] ^ i_b[MW-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= {w_hi, r_acc[MW-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_p    <= r_neg ? -$signed(r_acc) : $signed(r_acc);
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

// ===== rtl/akf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on akf_pkg for dividend and divisor widths.
module akf_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [akf_pkg::DNW-1:0]   i_num,
    input  logic [akf_pkg::DDW-1:0]   i_den,
    output logic                      o_done,
    output logic [akf_pkg::DNW-1:0]   o_q
);
    localparam int DNW = akf_pkg::DNW;
    localparam int DDW = akf_pkg::DDW;
    localparam int CW  = $clog2(DNW);

    logic           r_busy, r_done;
    logic [CW-1:0]  r_cnt;
    logic [DDW-1:0] r_rem, r_den;
    logic [DNW-1:0] r_q;
    logic [DDW:0]   w_sh;
    logic [DDW+1:0] w_diff;

    assign w_sh   = {r_rem, r_q[DNW-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_diff[DDW+1]) begin
                    r_rem <= w_diff[DDW-1:0];
                    r_q   <= {r_q[DNW-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh[DDW-1:0];
                    r_q   <= {r_q[DNW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DNW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

// ===== rtl/angle_kalman_filter_core.sv =====
// Angle/bias Kalman filter top level: sequencer, per-axis state, noise registers.
// Depends on akf_pkg, akf_mul and akf_div.
//
//  channel   valid     stall     payload
//  request   i_valid   o_stall   i_data  (akf_pkg::t_in)
//  result    o_valid   i_stall   o_data  (akf_pkg::t_out)
//  config    i_cfg_we  -         i_cfg_idx, i_cfg_data
//
// Each accepted request runs ten serial multiplies (issue, load, 36 bit steps, finish,
// handoff) and two serial divides (issue, load, 60 bit steps, handoff) one after
// another on the shared units; o_stall holds off the next request until the result
// is posted. Both divides are skipped, and both gains set to zero, when the
// innovation variance is not positive.
// Reset clears all axis state and loads the default noise values.
// A new request is taken while a result waits; finishing the next one holds on i_stall.
module angle_kalman_filter_core #(
    parameter int AXES = akf_pkg::AXES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  akf_pkg::t_in                   i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output akf_pkg::t_out                  o_data,
    input  logic                           i_cfg_we,
    input  logic [akf_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [akf_pkg::NOISE_W-1:0]    i_cfg_data
);
    localparam int MW = akf_pkg::MW;
    localparam int PW = akf_pkg::PW;
    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} t_state;
    typedef enum logic [3:0] {
        OP_ANG, OP_T, OP_P00, OP_P11, OP_K0, OP_K1,
        OP_CANG, OP_CBIA, OP_C00, OP_C01, OP_C10, OP_C11
    } t_op;

    t_state r_state;
    t_op    r_op;

    logic signed [31:0] r_st_ang [AXES];
    logic signed [31:0] r_st_bia [AXES];
    logic signed [31:0] r_st_p00 [AXES];
    logic signed [31:0] r_st_p01 [AXES];
    logic signed [31:0] r_st_p10 [AXES];
    logic signed [31:0] r_st_p11 [AXES];

    logic [akf_pkg::NOISE_W-1:0] r_an, r_bn, r_mn;

    logic [AW-1:0]      r_ax_idx;
    logic               r_ax;
    logic signed [31:0] r_ang, r_bia, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_z, r_w, r_k0, r_k1, r_q00, r_q01;
    logic [23:0]        r_dt;
    logic signed [33:0] r_t, r_y;
    logic               r_flag;
    logic               r_mul_go, r_div_go;
    logic               r_out_valid;
    akf_pkg::t_out      r_out;

    logic signed [MW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_prod, w_r24, w_r28;
    logic                 w_mul_done, w_div_done;
    logic [akf_pkg::DNW-1:0] w_q, w_num;
    logic signed [32:0]   w_s;
    logic                 w_s_pos, w_div_op, w_dneg;
    logic signed [31:0]   w_dsrc;
    logic [31:0]          w_dabs;
    logic [32:0]          w_sat_a, w_sat_b, w_sat_c, w_gain;
    logic signed [33:0]   w_y;
    logic [AW-1:0]        w_in_idx;

    assign w_in_idx = (AXES > 1) ? AW'(i_data.axis) : '0;

    assign w_s     = {r_p00[31], r_p00} + {4'b0000, r_mn};
    assign w_s_pos = !w_s[32] && (|w_s);
    assign w_div_op = (r_op == OP_K0) || (r_op == OP_K1);
    assign w_dsrc  = (r_op == OP_K0) ? r_p00 : r_p10;
    assign w_dneg  = w_dsrc[31];
    assign w_dabs  = w_dneg ? 32'(-w_dsrc) : 32'(w_dsrc);
    assign w_num   = {w_dabs, 28'd0};
    assign w_gain  = akf_pkg::sat_gain(w_q, w_dneg);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_op)
            OP_ANG: begin
                w_ma = MW'({1'b0, r_dt});
                w_mb = MW'(akf_pkg::ext32(r_w) - akf_pkg::ext32(r_bia));
            end
            OP_T: begin
                w_ma = MW'({1'b0, r_dt});
                w_mb = MW'(akf_pkg::ext32(r_p11));
            end
            OP_P00: begin
                w_ma = MW'({1'b0, r_dt});
                w_mb = MW'(akf_pkg::ext34(r_t) - akf_pkg::ext32(r_p01)
                           - akf_pkg::ext32(r_p10) + PW'({1'b0, r_an}));
            end
            OP_P11: begin
                w_ma = MW'({1'b0, r_bn});
                w_mb = MW'({1'b0, r_dt});
            end
            OP_CANG: begin w_ma = MW'(akf_pkg::ext32(r_k0)); w_mb = MW'(akf_pkg::ext34(r_y)); end
            OP_CBIA: begin w_ma = MW'(akf_pkg::ext32(r_k1)); w_mb = MW'(akf_pkg::ext34(r_y)); end
            OP_C00:  begin w_ma = MW'(akf_pkg::ext32(r_k0)); w_mb = MW'(akf_pkg::ext32(r_q00)); end
            OP_C01:  begin w_ma = MW'(akf_pkg::ext32(r_k0)); w_mb = MW'(akf_pkg::ext32(r_q01)); end
            OP_C10:  begin w_ma = MW'(akf_pkg::ext32(r_k1)); w_mb = MW'(akf_pkg::ext32(r_q00)); end
            OP_C11:  begin w_ma = MW'(akf_pkg::ext32(r_k1)); w_mb = MW'(akf_pkg::ext32(r_q01)); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    akf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_p     (w_prod)
    );

    akf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (w_num),
        .i_den   (w_s[31:0]),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    assign w_r24 = akf_pkg::rnd(w_prod, 24);
    assign w_r28 = akf_pkg::rnd(w_prod, 28);

    always_comb begin
        w_sat_a = '0;
        w_sat_b = '0;
        w_sat_c = '0;
        case (r_op)
            OP_ANG:  w_sat_a = akf_pkg::sat32(akf_pkg::ext32(r_ang) + w_r24);
            OP_P00: begin
                w_sat_a = akf_pkg::sat32(akf_pkg::ext32(r_p00) + w_r24);
                w_sat_b = akf_pkg::sat32(akf_pkg::ext32(r_p01) - akf_pkg::ext34(r_t));
                w_sat_c = akf_pkg::sat32(akf_pkg::ext32(r_p10) - akf_pkg::ext34(r_t));
            end
            OP_P11:  w_sat_a = akf_pkg::sat32(akf_pkg::ext32(r_p11) + w_r24);
            OP_CANG: w_sat_a = akf_pkg::sat32(akf_pkg::ext32(r_ang) + w_r28);
            OP_CBIA: w_sat_a = akf_pkg::sat32(akf_pkg::ext32(r_bia) + w_r28);
            OP_C00:  w_sat_a = akf_pkg::sat32(akf_pkg::ext32(r_p00) - w_r28);
            OP_C01:  w_sat_a = akf_pkg::sat32(akf_pkg::ext32(r_p01) - w_r28);
            OP_C10:  w_sat_a = akf_pkg::sat32(akf_pkg::ext32(r_p10) - w_r28);
            OP_C11:  w_sat_a = akf_pkg::sat32(akf_pkg::ext32(r_p11) - w_r28);
            default: w_sat_a = '0;
        endcase
    end

    assign w_y = {r_z[31], r_z[31], r_z} - {w_sat_a[31], w_sat_a[31], w_sat_a[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_ANG;
            r_mul_go    <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
            r_an        <= akf_pkg::ANGLE_NOISE_RST;
            r_bn        <= akf_pkg::BIAS_NOISE_RST;
            r_mn        <= akf_pkg::MEASURE_NOISE_RST;
            for (int i = 0; i < AXES; i++) begin
                r_st_ang[i] <= '0;
                r_st_bia[i] <= '0;
                r_st_p00[i] <= '0;
                r_st_p01[i] <= '0;
                r_st_p10[i] <= '0;
                r_st_p11[i] <= '0;
            end
        end else begin
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    akf_pkg::REG_ANGLE_NOISE:   r_an <= i_cfg_data;
                    akf_pkg::REG_BIAS_NOISE:    r_bn <= i_cfg_data;
                    akf_pkg::REG_MEASURE_NOISE: r_mn <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ax     <= i_data.axis;
                        r_ax_idx <= w_in_idx;
                        r_z      <= i_data.measured_angle;
                        r_w      <= i_data.measured_rate;
                        r_dt     <= i_data.time_step;
                        r_ang    <= r_st_ang[w_in_idx];
                        r_bia    <= r_st_bia[w_in_idx];
                        r_p00    <= r_st_p00[w_in_idx];
                        r_p01    <= r_st_p01[w_in_idx];
                        r_p10    <= r_st_p10[w_in_idx];
                        r_p11    <= r_st_p11[w_in_idx];
                        r_flag   <= 1'b0;
                        r_op     <= OP_ANG;
                        r_state  <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (w_div_op && !w_s_pos) begin
                        if (r_op == OP_K0) begin
                            r_k0 <= '0;
                        end else begin
                            r_k1 <= '0;
                        end
                        r_op <= t_op'(r_op + 1'b1);
                    end else begin
                        r_mul_go <= !w_div_op;
                        r_div_go <= w_div_op;
                        r_state  <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if ((w_div_op && w_div_done) || (!w_div_op && w_mul_done)) begin
                        r_state <= (r_op == OP_C11) ? S_DONE : S_ISSUE;
                        r_op    <= (r_op == OP_C11) ? r_op : t_op'(r_op + 1'b1);
                        r_flag  <= r_flag | w_sat_a[32] | w_sat_b[32] | w_sat_c[32]
                                   | (w_div_op & w_gain[32]);
                        case (r_op)
                            OP_ANG: begin
                                r_ang <= w_sat_a[31:0];
                                r_y   <= w_y;
                            end
                            OP_T:    r_t <= w_r24[33:0];
                            OP_P00: begin
                                r_p00 <= w_sat_a[31:0];
                                r_p01 <= w_sat_b[31:0];
                                r_p10 <= w_sat_c[31:0];
                            end
                            OP_P11: begin
                                r_p11 <= w_sat_a[31:0];
                                r_q00 <= r_p00;
                                r_q01 <= r_p01;
                            end
                            OP_K0:   r_k0  <= w_gain[31:0];
                            OP_K1:   r_k1  <= w_gain[31:0];
                            OP_CANG: r_ang <= w_sat_a[31:0];
                            OP_CBIA: r_bia <= w_sat_a[31:0];
                            OP_C00:  r_p00 <= w_sat_a[31:0];
                            OP_C01:  r_p01 <= w_sat_a[31:0];
                            OP_C10:  r_p10 <= w_sat_a[31:0];
                            OP_C11:  r_p11 <= w_sat_a[31:0];
                            default: ;
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_st_ang[r_ax_idx] <= r_ang;
                        r_st_bia[r_ax_idx] <= r_bia;
                        r_st_p00[r_ax_idx] <= r_p00;
                        r_st_p01[r_ax_idx] <= r_p01;
                        r_st_p10[r_ax_idx] <= r_p10;
                        r_st_p11[r_ax_idx] <= r_p11;
                        r_out.axis_out       <= r_ax;
                        r_out.filtered_angle <= r_ang;
                        r_out.bias_estimate  <= r_bia;
                        r_out.saturated      <= r_flag;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_done && w_div_done))
        else $error("multiplier and divider finished together");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mul_done || w_div_done) |-> (r_state == S_WAIT))
        else $error("arithmetic unit finished outside wait state");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_ISSUE && r_op == OP_ANG))
        else $error("accepted request did not start the sequence");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !(r_out_valid && i_stall)) |=> r_out_valid)
        else $error("finished request did not post a result");
endmodule

// ===== sim/tb_angle_kalman_filter_core.sv =====
// Self-checking testbench for angle_kalman_filter_core: predicts each filter update
// per axis in fixed point and compares every result. Depends on akf_pkg and the RTL.
`timescale 1ns / 1ps

module tb_angle_kalman_filter_core;

    localparam int  NAXES     = 2;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    akf_pkg::t_in                 i_data;
    logic                         o_valid;
    logic                         i_stall;
    akf_pkg::t_out                o_data;
    logic                         i_cfg_we;
    logic [akf_pkg::IDX_W-1:0]    i_cfg_idx;
    logic [akf_pkg::NOISE_W-1:0]  i_cfg_data;

    angle_kalman_filter_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    longint est_angle [NAXES];
    longint est_bias  [NAXES];
    longint p_aa [NAXES];
    longint p_ab [NAXES];
    longint p_ba [NAXES];
    longint p_bb [NAXES];
    longint q_angle, q_bias, r_meas;

    akf_pkg::t_out expected_updates[$];
    int     errors;
    longint cycles;
    int     burst_left;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint rshift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(longint v, inout bit f);
        if (v > 64'sd2147483647) begin
            f = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            f = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint clip_gain(longint v, inout bit f);
        if (v > 64'sd2147483647) begin
            f = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483647) begin
            f = 1'b1;
            return -64'sd2147483647;
        end
        return v;
    endfunction

    // signed 64-bit division truncating toward zero; products here stay below 2^60
    function automatic longint div_trunc(longint n, longint d);
        longint q;
        q = (n < 0 ? -n : n) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic akf_pkg::t_out predict_step(akf_pkg::t_in req);
        akf_pkg::t_out r;
        bit     f;
        int     a;
        longint z, w, dt, ang, bia, p00, p01, p10, p11, t, sum, s, k0, k1, y, q00, q01;
        f   = 1'b0;
        a   = req.axis % NAXES;
        z   = longint'(req.measured_angle);
        w   = longint'(req.measured_rate);
        dt  = longint'({40'd0, req.time_step});
        ang = est_angle[a];
        bia = est_bias[a];
        p00 = p_aa[a];
        p01 = p_ab[a];
        p10 = p_ba[a];
        p11 = p_bb[a];
        ang = clip32(ang + rshift(dt * (w - bia), 24), f);
        t   = rshift(dt * p11, 24);
        sum = t - p01 - p10 + q_angle;
        p00 = clip32(p00 + rshift(dt * sum, 24), f);
        p01 = clip32(p01 - t, f);
        p10 = clip32(p10 - t, f);
        p11 = clip32(p11 + rshift(q_bias * dt, 24), f);
        s   = p00 + r_meas;
        k0  = 0;
        k1  = 0;
        if (s > 0) begin
            k0 = clip_gain(div_trunc(p00 * 268435456, s), f);
            k1 = clip_gain(div_trunc(p10 * 268435456, s), f);
        end
        y   = z - ang;
        ang = clip32(ang + rshift(k0 * y, 28), f);
        bia = clip32(bia + rshift(k1 * y, 28), f);
        q00 = p00;
        q01 = p01;
        p00 = clip32(p00 - rshift(k0 * q00, 28), f);
        p01 = clip32(p01 - rshift(k0 * q01, 28), f);
        p10 = clip32(p10 - rshift(k1 * q00, 28), f);
        p11 = clip32(p11 - rshift(k1 * q01, 28), f);
        est_angle[a] = ang;
        est_bias[a]  = bia;
        p_aa[a] = p00;
        p_ab[a] = p01;
        p_ba[a] = p10;
        p_bb[a] = p11;
        r.axis_out       = req.axis;
        r.filtered_angle = ang[31:0];
        r.bias_estimate  = bia[31:0];
        r.saturated      = f;
        return r;
    endfunction

    task automatic send_request(akf_pkg::t_in req);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (o_stall);
        expected_updates.push_back(predict_step(req));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_updates.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_noise(logic [akf_pkg::IDX_W-1:0] idx,
                               logic [akf_pkg::NOISE_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == akf_pkg::REG_ANGLE_NOISE) q_angle = v;
        else if (idx == akf_pkg::REG_BIAS_NOISE) q_bias = v;
        else if (idx == akf_pkg::REG_MEASURE_NOISE) r_meas = v;
    endtask

    function automatic akf_pkg::t_in make_req(logic ax, int ang, int rate, logic [23:0] dt);
        akf_pkg::t_in r;
        r.axis = ax;
        r.measured_angle = ang;
        r.measured_rate = rate;
        r.time_step = dt;
        return r;
    endfunction

    function automatic akf_pkg::t_in random_req(bit wild);
        akf_pkg::t_in r;
        r.axis = 1'($urandom_range(0, 1));
        if (wild) begin
            r.measured_angle = $urandom;
            r.measured_rate  = $urandom;
            r.time_step      = 24'($urandom);
        end else begin
            r.measured_angle = $signed($urandom_range(0, 23592960)) - 11796480;
            r.measured_rate  = $signed($urandom_range(0, 32768000)) - 16384000;
            r.time_step      = 24'($urandom_range(1000, 170000));
        end
        return r;
    endfunction

    task automatic test_directed_extremes();
        send_request(make_req(1'b0, 0, 0, 24'd0));
        send_request(make_req(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF));
        send_request(make_req(1'b0, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF));
        send_request(make_req(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF));
        send_request(make_req(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 24'd1));
        send_request(make_req(1'b1, 32'h0A00_0000, 32'h0000_1000, 24'd16777));
        send_request(make_req(1'b0, -32'sd5000, 32'h00FF_0000, 24'h80_0000));
        for (int i = 0; i < 8; i++) send_request(random_req(1'b1));
    endtask

    task automatic test_zero_measure_noise();
        write_noise(akf_pkg::REG_MEASURE_NOISE, '0);
        for (int i = 0; i < 10; i++) send_request(random_req(i[0]));
    endtask

    task automatic test_noise_extremes();
        write_noise(akf_pkg::REG_ANGLE_NOISE, 29'h1000_0000);
        write_noise(akf_pkg::REG_BIAS_NOISE, 29'h1000_0000);
        write_noise(akf_pkg::REG_MEASURE_NOISE, 29'd1);
        for (int i = 0; i < 20; i++) send_request(random_req(i % 3 == 0));
        write_noise(akf_pkg::REG_ANGLE_NOISE, '0);
        write_noise(akf_pkg::REG_BIAS_NOISE, '0);
        write_noise(akf_pkg::REG_MEASURE_NOISE, 29'h1FFF_FFFF);
        for (int i = 0; i < 20; i++) send_request(random_req(i % 3 == 0));
    endtask

    task automatic test_random_tracking();
        for (int ph = 0; ph < 4; ph++) begin
            write_noise(akf_pkg::REG_ANGLE_NOISE, 29'($urandom_range(0, 2000000)));
            write_noise(akf_pkg::REG_BIAS_NOISE, 29'($urandom_range(0, 4000000)));
            write_noise(akf_pkg::REG_MEASURE_NOISE, 29'($urandom_range(1, 60000000)));
            for (int i = 0; i < 380; i++)
                send_request(random_req($urandom_range(0, 9) == 0));
        end
        write_noise(akf_pkg::REG_ANGLE_NOISE, akf_pkg::ANGLE_NOISE_RST);
        write_noise(akf_pkg::REG_BIAS_NOISE, akf_pkg::BIAS_NOISE_RST);
        write_noise(akf_pkg::REG_MEASURE_NOISE, akf_pkg::MEASURE_NOISE_RST);
        for (int i = 0; i < 60; i++) send_request(random_req(1'b0));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cycles % 200 < 100) i_stall <= ($urandom_range(0, 3) == 0);
            else i_stall <= 1'b0;
            if (o_valid && !i_stall) begin
                if (expected_updates.size() == 0) begin
                    $display("%0t unexpected result %p", $time, o_data);
                    errors++;
                end else if (o_data !== expected_updates[0]) begin
                    $display("%0t mismatch expected %p actual %p", $time,
                             expected_updates[0], o_data);
                    errors++;
                    void'(expected_updates.pop_front());
                end else begin
                    void'(expected_updates.pop_front());
                end
            end
        end
    end

    initial begin
        i_clk      = 1'b0;
        errors     = 0;
        cycles     = 0;
        burst_left = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_stall    = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        for (int a = 0; a < NAXES; a++) begin
            est_angle[a] = 0; est_bias[a] = 0;
            p_aa[a] = 0; p_ab[a] = 0; p_ba[a] = 0; p_bb[a] = 0;
        end
        q_angle = akf_pkg::ANGLE_NOISE_RST;
        q_bias  = akf_pkg::BIAS_NOISE_RST;
        r_meas  = akf_pkg::MEASURE_NOISE_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_zero_measure_noise();
        test_noise_extremes();
        test_random_tracking();
        drain();
        if (errors == 0 && expected_updates.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
